### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; compiled out when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### design/xs128a_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xs128a_pkg
// Types, constants and helpers shared by the xorshift128+ generator unit.
// ---------------------------------------------------------------------------
package xs128a_pkg;

	localparam int WORD_W        = 64;
	localparam int COUNT_W       = 7;
	localparam int ADDR_W        = 4;
	localparam int DEF_MAX_CHARS = 64;
	localparam int WORD_CAP      = 4096;
	localparam int WORDS_W       = $clog2(WORD_CAP + 1);

	localparam logic CMD_RAW = 1'b0;
	localparam logic CMD_STR = 1'b1;

	typedef struct packed {
		logic raw;
		logic start;
		logic take;
		logic step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic mask_nz;
		logic left_zero;
		logic cap_hit;
		logic pend_v;
	} dp_sts_t;

	function automatic logic is_alnum(input logic [7:0] ch);
		return (ch >= 8'h30 && ch <= 8'h39) ||
		       (ch >= 8'h41 && ch <= 8'h5A) ||
		       (ch >= 8'h61 && ch <= 8'h7A);
	endfunction

endpackage

### design/xorshift128plus_alnum_generator_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xorshift128plus_alnum_generator_unit
// xorshift128+ generator returning raw 64-bit words or alphanumeric strings.
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  request  | req_valid/req_stall  | command, count
//  result   | rsp_valid/rsp_stall  | value, last
//  config   | APB psel/penable     | seed_first @ 0x0, seed_second @ 0x8
//
// Raw word: one generator step per request.
// String: a start, then one character per take and one generator word per step,
//   then a close; the scan is bounded at 4096 words.
// Reset loads zero seeds into the generator state.
// A stalled result holds the scan; one character is kept back to mark last.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module xorshift128plus_alnum_generator_unit
	import xs128a_pkg::*;
#(
	parameter int MAX_CHARS = DEF_MAX_CHARS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               command,
	input  logic [COUNT_W-1:0] count,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [WORD_W-1:0]  value,
	output logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [WORD_W-1:0]  pwdata,
	output logic [WORD_W-1:0]  prdata,
	output logic               pready
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    busy;
	logic    cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	xs128a_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.command   (command),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	xs128a_dp #(
		.MAX_CHARS (MAX_CHARS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.count     (count),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_wr    (cfg_wr),
		.cfg_sel   (paddr[3]),
		.cfg_wdata (pwdata),
		.cfg_rdata (prdata),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.value     (value),
		.last      (last)
	);

	`ASSERT_IMP(a_last_when_idle, clk, arst_n, rsp_valid && last, !busy)
	`ASSERT_IMP(a_no_pend_idle, clk, arst_n, !busy, !sts.pend_v)
	`ASSERT_IMP(a_done_has_pend, clk, arst_n, busy && sts.left_zero, sts.pend_v)
	`ASSERT_NXT(a_finish_last, clk, arst_n, cmd.finish, rsp_valid && last)

endmodule

### design/xs128a_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xs128a_ctrl
// Request sequencer: starts raw and string requests, paces the byte scan.
// ---------------------------------------------------------------------------
module xs128a_ctrl
	import xs128a_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_stall,
	input  logic    command,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	output logic    busy
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	assign busy      = (state_q != ST_IDLE);
	assign req_stall = busy || !sts.out_free;
	assign accept    = req_valid && !req_stall;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (command == CMD_RAW) begin
						cmd.raw = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (sts.out_free) begin
					if (sts.left_zero) begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end else if (sts.mask_nz) begin
						cmd.take = 1'b1;
					end else if (sts.cap_hit) begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### design/xs128a_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xs128a_dp
// Generator state, seed registers, byte scanner and result register.
// ---------------------------------------------------------------------------
module xs128a_dp
	import xs128a_pkg::*;
#(
	parameter int MAX_CHARS = DEF_MAX_CHARS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [COUNT_W-1:0] count,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	input  logic               cfg_wr,
	input  logic               cfg_sel,
	input  logic [WORD_W-1:0]  cfg_wdata,
	output logic [WORD_W-1:0]  cfg_rdata,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [WORD_W-1:0]  value,
	output logic               last
);

	localparam int LEFT_W = $clog2(MAX_CHARS + 1);
	localparam int CMP_W  = (LEFT_W > COUNT_W) ? LEFT_W : COUNT_W;

	logic [WORD_W-1:0]  seed0_q, seed1_q;
	logic [WORD_W-1:0]  st0_q, st1_q;
	logic [WORD_W-1:0]  word_q;
	logic [7:0]         mask_q;
	logic [WORDS_W-1:0] words_q;
	logic [LEFT_W-1:0]  left_q;
	logic [7:0]         pend_q;
	logic               pend_v_q;
	logic               rsp_valid_q;
	logic [WORD_W-1:0]  rsp_value_q;
	logic               rsp_last_q;

	logic [WORD_W-1:0]  mix_a, mix_c, gen_sum;
	logic [WORD_W-1:0]  new_seed0, new_seed1;
	logic [7:0]         new_mask, pick_oh;
	logic [7:0]         pick_ch;
	logic [CMP_W-1:0]   cnt_ext, want;
	logic               emit;
	logic [WORD_W-1:0]  emit_value;
	logic               emit_last;

	// xorshift128+ step
	assign mix_a   = st0_q ^ (st0_q << 23);
	assign mix_c   = mix_a ^ st1_q ^ (mix_a >> 17) ^ (st1_q >> 26);
	assign gen_sum = mix_c + st1_q;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			new_mask[i] = is_alnum(gen_sum[8*i +: 8]);
		end
	end

	// lowest pending alnum byte
	assign pick_oh = mask_q & (~mask_q + 8'd1);
	always_comb begin
		pick_ch = '0;
		for (int i = 0; i < 8; i++) begin
			pick_ch = pick_ch | (word_q[8*i +: 8] & {8{pick_oh[i]}});
		end
	end

	assign cnt_ext = CMP_W'(count);
	always_comb begin
		if (cnt_ext == '0) begin
			want = CMP_W'(1);
		end else if (cnt_ext > CMP_W'(MAX_CHARS)) begin
			want = CMP_W'(MAX_CHARS);
		end else begin
			want = cnt_ext;
		end
	end

	assign new_seed0 = cfg_sel ? seed0_q : cfg_wdata;
	assign new_seed1 = cfg_sel ? cfg_wdata : seed1_q;
	assign cfg_rdata = cfg_sel ? seed1_q : seed0_q;

	always_comb begin
		emit       = 1'b0;
		emit_value = '0;
		emit_last  = 1'b0;
		if (cmd.raw) begin
			emit       = 1'b1;
			emit_value = gen_sum;
			emit_last  = 1'b1;
		end else if (cmd.take) begin
			emit       = pend_v_q;
			emit_value = WORD_W'(pend_q);
		end else if (cmd.finish) begin
			emit       = 1'b1;
			emit_value = pend_v_q ? WORD_W'(pend_q) : '0;
			emit_last  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed0_q     <= '0;
			seed1_q     <= '0;
			st0_q       <= '0;
			st1_q       <= '0;
			pend_v_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
			mask_q      <= '0;
			words_q     <= '0;
			left_q      <= '0;
		end else begin
			if (cfg_wr) begin
				seed0_q <= new_seed0;
				seed1_q <= new_seed1;
				st0_q   <= new_seed0;
				st1_q   <= new_seed1;
			end else if (cmd.raw || cmd.step) begin
				st0_q <= st1_q;
				st1_q <= mix_c;
			end

			if (cmd.start) begin
				left_q   <= LEFT_W'(want);
				words_q  <= '0;
				mask_q   <= '0;
				pend_v_q <= 1'b0;
			end else if (cmd.step) begin
				mask_q  <= new_mask;
				words_q <= words_q + WORDS_W'(1);
			end else if (cmd.take) begin
				mask_q   <= mask_q & (mask_q - 8'd1);
				left_q   <= left_q - LEFT_W'(1);
				pend_v_q <= 1'b1;
			end else if (cmd.finish) begin
				pend_v_q <= 1'b0;
				left_q   <= '0;
			end

			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			word_q <= gen_sum;
		end
		if (cmd.take) begin
			pend_q <= pick_ch;
		end
		if (emit) begin
			rsp_value_q <= emit_value;
			rsp_last_q  <= emit_last;
		end
	end

	assign sts.out_free  = !rsp_valid_q || !rsp_stall;
	assign sts.mask_nz   = (mask_q != '0);
	assign sts.left_zero = (left_q == '0);
	assign sts.cap_hit   = (words_q == WORDS_W'(WORD_CAP));
	assign sts.pend_v    = pend_v_q;

	assign rsp_valid = rsp_valid_q;
	assign value     = rsp_value_q;
	assign last      = rsp_last_q;

endmodule
